/* sv/gbba_pkg.sv */
package gbba_pkg;

  // Width of all block-number arithmetic: group index times blocks per group plus one
  // more group still fits.
  localparam int unsigned ARITH_W = 26;
  localparam int unsigned BLK_W   = 16;
  localparam int unsigned CNT_W   = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int unsigned MIN_BPG = 8;

  localparam int unsigned MAX_BLOCKS_DEF = 65536;
  localparam int unsigned MAX_GROUPS_DEF = 16;
  localparam int unsigned WORD_BITS_DEF  = 64;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  typedef logic [ARITH_W-1:0] arith_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROUP_MODE  = 3'd0,
    REG_PREALLOC    = 3'd1,
    REG_TOTAL       = 3'd2,
    REG_FIRST_DATA  = 3'd3,
    REG_BPG         = 3'd4,
    REG_GROUP_COUNT = 3'd5,
    REG_GROUP_META  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOSPACE = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Normalized geometry shared by the range unit and the sequencer.
  typedef struct packed {
    arith_t n_total;
    arith_t bpg;
    arith_t fdb;
    arith_t meta;
  } geom_t;

  // Extent of one group: first block, data range [lo, hi) and its size.
  typedef struct packed {
    arith_t first;
    arith_t lo;
    arith_t hi;
    arith_t data;
  } grp_range_t;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DIV_F = 13'b0000000000100,
    S_DIV_B = 13'b0000000001000,
    S_VALID = 13'b0000000010000,
    S_FCHK  = 13'b0000000100000,
    S_START = 13'b0000001000000,
    S_GRP   = 13'b0000010000000,
    S_NEXT  = 13'b0000100000000,
    S_RD    = 13'b0001000000000,
    S_CHK   = 13'b0010000000000,
    S_SUM   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  function automatic arith_t amax(input arith_t a, input arith_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

/* sv/gbba_bitmap.sv */
module gbba_bitmap #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned ADDR_W    = 10
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_W-1:0]    waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic [ADDR_W-1:0]    raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* sv/gbba_grp_calc.sv */
module gbba_grp_calc #(
  parameter int unsigned GC_W = 5
) (
  input  logic [GC_W-1:0]      g_i,
  input  gbba_pkg::geom_t      geom_i,
  output gbba_pkg::grp_range_t rng_o
);
  import gbba_pkg::*;

  localparam int unsigned PW = GC_W + 17;

  logic [PW-1:0] prod;
  arith_t first, endv, lim, l;
  logic   empty;

  assign prod  = {{17{1'b0}}, g_i} * {{GC_W{1'b0}}, geom_i.bpg[16:0]};
  assign first = ARITH_W'(prod);

  always_comb begin
    lim  = first + geom_i.bpg;
    endv = (lim > geom_i.n_total) ? geom_i.n_total : lim;
    l    = (g_i == '0) ? geom_i.fdb : first + geom_i.meta;
    l    = amax(l, geom_i.fdb);
    l    = amax(l, first);
    l    = amax(l, ARITH_W'(1));
    empty = (first >= geom_i.n_total) || (l >= endv);
    rng_o.first = first;
    rng_o.lo    = empty ? '0 : l;
    rng_o.hi    = empty ? '0 : endv;
    rng_o.data  = empty ? '0 : endv - l;
  end

endmodule

/* sv/gbba_ffz.sv */
module gbba_ffz #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned WB_W      = 6
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [WB_W-1:0]      lo_bit_i,
  input  logic [WB_W-1:0]      hi_bit_i,
  output logic                 found_o,
  output logic [WB_W-1:0]      idx_o
);

  logic [WORD_BITS-1:0] cand, lowest;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      cand[i] = !word_i[i] && (WB_W'(i) >= lo_bit_i) && (WB_W'(i) <= hi_bit_i);
    end
  end

  // Isolate the lowest free bit and encode its position.
  assign lowest  = cand & (~cand + 1'b1);
  assign found_o = |cand;

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      idx_o = idx_o | (lowest[i] ? WB_W'(i) : '0);
    end
  end

endmodule

/* sv/group_block_bitmap_allocator_top.sv */
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  command item (alloc or free)
// m_axis    out        m_axis_tvalid / m_axis_tready  result item, one per command
// cfg       in         cfg_valid_i / cfg_ready_o      register index and write data
//
// After reset the bitmap memory is cleared one word per cycle, all DEPTH words
// (1024 at the defaults); no item is accepted meanwhile, configuration writes are.
// A free runs the group divide in group mode, checks the address and updates the bitmap,
// then totals the data blocks. An allocate runs the group divides in group mode, visits
// groups and scans bitmap words through the single memory read port, and ends with the
// same final total.
// One item is in flight at a time; the result register lets the next item enter while
// the previous result still waits for m_axis_tready.
module group_block_bitmap_allocator_top #(
  parameter int unsigned MAX_BLOCKS = gbba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned MAX_GROUPS = gbba_pkg::MAX_GROUPS_DEF,
  parameter int unsigned WORD_BITS  = gbba_pkg::WORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: block_addr[15:0], pref_group[19:16], pref_group_valid[20], zero pad [23:21]
  input  logic [23:0]                       s_axis_tdata,
  // tuser: cmd[0]
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: block_out[15:0], free_blocks[32:16], zero pad [39:33]
  output logic [39:0]                       m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gbba_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [gbba_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import gbba_pkg::*;

  localparam int unsigned DEPTH  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WB_W   = $clog2(WORD_BITS);
  localparam int unsigned GC_W   = $clog2(MAX_GROUPS + 1);
  localparam int unsigned GI_W   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  // Configuration registers.
  logic        group_mode_q, prealloc_q;
  logic [16:0] total_q, bpg_q;
  logic [15:0] fdb_q, meta_q;
  logic [4:0]  gcount_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_mode_q <= 1'b1;
      prealloc_q   <= 1'b0;
      total_q      <= 17'd65536;
      fdb_q        <= 16'd64;
      bpg_q        <= 17'd8192;
      gcount_q     <= 5'd8;
      meta_q       <= 16'd34;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_GROUP_MODE:  group_mode_q <= cfg_data_i[0];
        REG_PREALLOC:    prealloc_q   <= cfg_data_i[0];
        REG_TOTAL:       total_q      <= cfg_data_i;
        REG_FIRST_DATA:  fdb_q        <= cfg_data_i[15:0];
        REG_BPG:         bpg_q        <= cfg_data_i;
        REG_GROUP_COUNT: gcount_q     <= cfg_data_i[4:0];
        REG_GROUP_META:  meta_q       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Out-of-range register values are folded into their legal range here.
  geom_t           geom;
  logic [GC_W-1:0] n_gc;

  always_comb begin
    geom.n_total = (ARITH_W'(total_q) > ARITH_W'(MAX_BLOCKS)) ? ARITH_W'(MAX_BLOCKS)
                                                               : ARITH_W'(total_q);
    geom.bpg  = (ARITH_W'(bpg_q) < ARITH_W'(MIN_BPG)) ? ARITH_W'(MIN_BPG) : ARITH_W'(bpg_q);
    geom.fdb  = ARITH_W'(fdb_q);
    geom.meta = ARITH_W'(meta_q);
    if (gcount_q == '0) begin
      n_gc = GC_W'(1);
    end else if (9'(gcount_q) > 9'(MAX_GROUPS)) begin
      n_gc = GC_W'(MAX_GROUPS);
    end else begin
      n_gc = GC_W'(gcount_q);
    end
  end

  // Sequencer state.
  state_e          state_q, state_d;
  logic            cmd_q, cmd_d;
  logic [15:0]     addr_q, addr_d;
  logic [3:0]      ggrp_q, ggrp_d;
  logic            gval_q, gval_d;
  logic [GC_W-1:0] divq_q, divq_d, fdg_q, fdg_d, bq_q, bq_d, g_q, g_d, s_q, s_d;
  arith_t          divn_q, divn_d;
  logic            have_blk_q, have_blk_d;
  arith_t          sa_q, sa_d, se_q, se_d, r2a_q, r2a_d, r2e_q, r2e_d, wq_q, wq_d;
  logic            r2_q, r2_d;
  logic [15:0]     blk_q, blk_d;
  status_e         status_q, status_d;
  arith_t          acc_q, acc_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]  gused_q [MAX_GROUPS];
  logic [CNT_W-1:0]  tused_q, tused_d;
  logic [15:0]       hint_q, hint_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [15:0]       out_blk_q, out_blk_d;
  logic [CNT_W-1:0]  out_free_q, out_free_d;

  logic              gu_we;
  logic [GI_W-1:0]   gu_idx;
  logic [CNT_W-1:0]  gu_val;

  // Shared group range unit.
  logic [GC_W-1:0] calc_g;
  grp_range_t      rng;

  gbba_grp_calc #(.GC_W(GC_W)) u_calc (
    .g_i    (calc_g),
    .geom_i (geom),
    .rng_o  (rng)
  );

  // Bitmap memory.
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  gbba_bitmap #(.WORD_BITS(WORD_BITS), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Free-bit search inside the current word.
  arith_t          a_w, l_w;
  logic [WB_W-1:0] lo_bit, hi_bit, ffz_idx;
  logic            ffz_found;

  always_comb begin
    a_w    = sa_q >> WB_W;
    l_w    = (se_q - ARITH_W'(1)) >> WB_W;
    lo_bit = (wq_q == a_w) ? sa_q[WB_W-1:0] : '0;
    hi_bit = (wq_q == l_w) ? WB_W'(se_q - ARITH_W'(1)) : '1;
  end

  gbba_ffz #(.WORD_BITS(WORD_BITS), .WB_W(WB_W)) u_ffz (
    .word_i   (mem_rdata),
    .lo_bit_i (lo_bit),
    .hi_bit_i (hi_bit),
    .found_o  (ffz_found),
    .idx_o    (ffz_idx)
  );

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    logic            have_grp, div_hit, div_last, valid, skip, go_sum;
    logic [GC_W-1:0] div_res, start_g;
    arith_t          a, hint, start, flat_lo, blk, used_g, free_w;
    logic [WORD_BITS-1:0] bit_m;

    state_d = state_q;  cmd_d = cmd_q;  addr_d = addr_q;  ggrp_d = ggrp_q;
    gval_d = gval_q;    divq_d = divq_q; divn_d = divn_q; fdg_d = fdg_q;
    bq_d = bq_q;        g_d = g_q;      s_d = s_q;      have_blk_d = have_blk_q;
    sa_d = sa_q;        se_d = se_q;    r2_d = r2_q;    r2a_d = r2a_q;
    r2e_d = r2e_q;      wq_d = wq_q;    blk_d = blk_q;  status_d = status_q;
    acc_d = acc_q;      clr_d = clr_q;  tused_d = tused_q; hint_d = hint_q;
    out_valid_d = out_valid_q; out_status_d = out_status_q;
    out_blk_d = out_blk_q;     out_free_d = out_free_q;
    gu_we = 1'b0; gu_idx = GI_W'(g_q); gu_val = '0;
    mem_we = 1'b0; mem_waddr = ADDR_W'(wq_q); mem_wdata = '0;
    mem_raddr = ADDR_W'(wq_q);
    go_sum = 1'b0;
    valid = 1'b0; skip = 1'b0; start_g = '0; hint = '0; start = '0;
    flat_lo = '0; blk = '0; free_w = '0; bit_m = '0;

    have_grp = gval_q && (9'(ggrp_q) < 9'(n_gc));
    a        = ARITH_W'(addr_q);
    used_g   = ARITH_W'(gused_q[GI_W'(g_q)]);

    unique case (state_q)
      S_DIV_F, S_DIV_B: calc_g = divq_q + GC_W'(1);
      S_VALID:          calc_g = bq_q;
      default:          calc_g = g_q;
    endcase

    div_hit  = divn_q < rng.first;
    div_last = (divq_q + GC_W'(1)) == n_gc;
    div_res  = div_hit ? divq_q : divq_q + GC_W'(1);

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d    = s_axis_tuser;
          addr_d   = s_axis_tdata[15:0];
          ggrp_d   = s_axis_tdata[19:16];
          gval_d   = s_axis_tdata[20];
          blk_d    = '0;
          status_d = STATUS_OK;
          divq_d   = '0;
          if (s_axis_tuser == CMD_FREE) begin
            if (group_mode_q) begin
              divn_d  = ARITH_W'(s_axis_tdata[15:0]);
              state_d = S_DIV_B;
            end else begin
              state_d = S_VALID;
            end
          end else if (group_mode_q) begin
            divn_d  = geom.fdb;
            state_d = S_DIV_F;
          end else begin
            // Flat mode: one upward scan from the first data block.
            flat_lo = amax(geom.fdb, ARITH_W'(1));
            sa_d    = flat_lo;
            se_d    = geom.n_total;
            r2_d    = 1'b0;
            wq_d    = flat_lo >> WB_W;
            if (flat_lo >= geom.n_total) begin
              status_d = STATUS_NOSPACE;
              go_sum   = 1'b1;
            end else begin
              state_d = S_RD;
            end
          end
        end
      end
      S_DIV_F: begin
        if (div_hit || div_last) begin
          fdg_d = div_res;
          if (prealloc_q && addr_q != '0) begin
            divn_d  = a;
            divq_d  = '0;
            state_d = S_DIV_B;
          end else begin
            have_blk_d = 1'b0;
            state_d    = S_START;
          end
        end else begin
          divq_d = divq_q + GC_W'(1);
        end
      end
      S_DIV_B: begin
        if (div_hit || div_last) begin
          bq_d    = div_res;
          state_d = S_VALID;
        end else begin
          divq_d = divq_q + GC_W'(1);
        end
      end
      S_VALID: begin
        if (group_mode_q) begin
          valid = (a != '0) && (a < geom.n_total) && (bq_q < n_gc) &&
                  ((bq_q == '0) ? (a >= geom.fdb) : (a >= rng.first + geom.meta));
        end else begin
          valid = (a != '0) && (a < geom.n_total) && (a >= geom.fdb);
        end
        mem_raddr = ADDR_W'(a >> WB_W);
        if (cmd_q == CMD_ALLOC) begin
          have_blk_d = valid;
          state_d    = S_START;
        end else if (!valid) begin
          status_d = STATUS_INVALID;
          go_sum   = 1'b1;
        end else begin
          state_d = S_FCHK;
        end
      end
      S_FCHK: begin
        bit_m = {{(WORD_BITS-1){1'b0}}, 1'b1} << addr_q[WB_W-1:0];
        if ((mem_rdata & bit_m) != '0) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(a >> WB_W);
          mem_wdata = mem_rdata & ~bit_m;
          if (group_mode_q) begin
            gu_we  = 1'b1;
            gu_idx = GI_W'(bq_q);
            gu_val = (gused_q[GI_W'(bq_q)] == '0) ? '0 : gused_q[GI_W'(bq_q)] - 1'b1;
          end
          tused_d = (tused_q == '0) ? '0 : tused_q - 1'b1;
        end
        go_sum = 1'b1;
      end
      S_START: begin
        if (prealloc_q && have_grp) begin
          start_g = GC_W'(ggrp_q);
        end else if (prealloc_q && have_blk_q) begin
          start_g = bq_q;
        end else begin
          start_g = fdg_q;
        end
        if (start_g >= n_gc) begin
          status_d = STATUS_NOSPACE;
          go_sum   = 1'b1;
        end else begin
          g_d     = start_g;
          s_d     = '0;
          state_d = S_GRP;
        end
      end
      S_GRP: begin
        skip = (g_q < fdg_q) || (rng.data <= used_g);
        if (prealloc_q) begin
          if (have_blk_q && bq_q == g_q) begin
            hint = a;
          end else if (have_grp && g_q == GC_W'(ggrp_q) &&
                       ARITH_W'(hint_q) >= rng.first && ARITH_W'(hint_q) < rng.hi) begin
            hint = ARITH_W'(hint_q);
          end else begin
            hint = '0;
          end
        end else begin
          hint = (s_q == '0) ? ARITH_W'(hint_q) : '0;
        end
        start = (hint >= rng.first && hint < rng.hi) ? hint : rng.first;
        if (skip) begin
          state_d = S_NEXT;
        end else begin
          // Search from the start point to the group end, then wrap up to it.
          sa_d    = amax(start, rng.lo);
          se_d    = rng.hi;
          wq_d    = amax(start, rng.lo) >> WB_W;
          r2_d    = start > rng.lo;
          r2a_d   = rng.lo;
          r2e_d   = start;
          state_d = S_RD;
        end
      end
      S_NEXT: begin
        if (s_q + GC_W'(1) == n_gc) begin
          status_d = STATUS_NOSPACE;
          go_sum   = 1'b1;
        end else begin
          s_d     = s_q + GC_W'(1);
          g_d     = (g_q + GC_W'(1) == n_gc) ? '0 : g_q + GC_W'(1);
          state_d = S_GRP;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (ffz_found) begin
          blk       = (wq_q << WB_W) | ARITH_W'(ffz_idx);
          bit_m     = {{(WORD_BITS-1){1'b0}}, 1'b1} << ffz_idx;
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | bit_m;
          blk_d     = blk[15:0];
          hint_d    = blk[15:0] + 16'd1;
          tused_d   = (tused_q == CNT_MAX) ? CNT_MAX : tused_q + 1'b1;
          if (group_mode_q) begin
            gu_we  = 1'b1;
            gu_val = (gused_q[GI_W'(g_q)] == CNT_MAX) ? CNT_MAX
                                                     : gused_q[GI_W'(g_q)] + 1'b1;
          end
          go_sum = 1'b1;
        end else if (wq_q == l_w) begin
          if (r2_q) begin
            sa_d    = r2a_q;
            se_d    = r2e_q;
            wq_d    = r2a_q >> WB_W;
            r2_d    = 1'b0;
            state_d = S_RD;
          end else if (group_mode_q) begin
            state_d = S_NEXT;
          end else begin
            status_d = STATUS_NOSPACE;
            go_sum   = 1'b1;
          end
        end else begin
          wq_d    = wq_q + ARITH_W'(1);
          state_d = S_RD;
        end
      end
      S_SUM: begin
        if (group_mode_q) begin
          acc_d = acc_q + rng.data;
          g_d   = g_q + GC_W'(1);
          if (g_q + GC_W'(1) == n_gc) begin
            state_d = S_OUT;
          end
        end else begin
          flat_lo = amax(geom.fdb, ARITH_W'(1));
          acc_d   = (geom.n_total > flat_lo) ? geom.n_total - flat_lo : '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        free_w = (acc_q > ARITH_W'(tused_q)) ? acc_q - ARITH_W'(tused_q) : '0;
        if (!m_axis_tvalid || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_blk_d    = blk_q;
          out_free_d   = (free_w > ARITH_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(free_w);
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (go_sum) begin
      g_d     = '0;
      acc_d   = '0;
      state_d = S_SUM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      tused_q     <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        gused_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      tused_q     <= tused_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
      if (gu_we) begin
        gused_q[gu_idx] <= gu_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;   addr_q <= addr_d;   ggrp_q <= ggrp_d;   gval_q <= gval_d;
    divq_q <= divq_d; divn_q <= divn_d;   fdg_q <= fdg_d;     bq_q <= bq_d;
    g_q <= g_d;       s_q <= s_d;         have_blk_q <= have_blk_d;
    sa_q <= sa_d;     se_q <= se_d;       r2_q <= r2_d;       r2a_q <= r2a_d;
    r2e_q <= r2e_d;   wq_q <= wq_d;       blk_q <= blk_d;     status_q <= status_d;
    acc_q <= acc_d;
    out_status_q <= out_status_d;
    out_blk_q    <= out_blk_d;
    out_free_q   <= out_free_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'd0, out_free_q, out_blk_q};

endmodule
